### rtl/core/csa_pkg.sv
package csa_pkg;

	// Queue between the front and back parts; depth is a power of two so the
	// pointers wrap on their own.
	localparam int QDEPTH = 4;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [63:0]  left;
		logic signed [63:0]  right;
	} req_t;

	typedef struct packed {
		logic signed [63:0]  result;
		logic [1:0]          status;
	} rsp_t;

	// Classified operation; only the low DATA_WIDTH bits of a, b, am, bm count.
	typedef struct packed {
		op_t         op;
		status_t     st;
		logic        neg;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] am;
		logic [63:0] bm;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

### rtl/core/csa_front.sv
module csa_front #(
	parameter int W = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  csa_pkg::req_t   req,
	input  csa_pkg::qstat_t qstat,
	output logic            push,
	output csa_pkg::item_t  push_item
);

	localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

	logic          valid_s1;
	csa_pkg::req_t req_s1;

	logic [W-1:0]      a_w, b_w, am_w, bm_w;
	logic              sa, sb;
	csa_pkg::op_t      op;
	csa_pkg::status_t  st;

	assign req_stall = valid_s1 && qstat.full;
	assign push      = valid_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	always_comb begin
		a_w  = req_s1.left[W-1:0];
		b_w  = req_s1.right[W-1:0];
		sa   = a_w[W-1];
		sb   = b_w[W-1];
		am_w = sa ? ('0 - a_w) : a_w;
		bm_w = sb ? ('0 - b_w) : b_w;
		op   = csa_pkg::op_t'(req_s1.func);
		st   = csa_pkg::ST_OK;
		// Divide errors are known up front: zero divisor, then min over -1.
		if (op == csa_pkg::OP_DIV) begin
			if (b_w == '0) begin
				st = csa_pkg::ST_DIV0;
			end else if (a_w == MIN_W && b_w == '1) begin
				st = csa_pkg::ST_OVF;
			end
		end
		push_item.op  = op;
		push_item.st  = st;
		push_item.neg = sa ^ sb;
		push_item.a   = 64'(a_w);
		push_item.b   = 64'(b_w);
		push_item.am  = 64'(am_w);
		push_item.bm  = 64'(bm_w);
	end

endmodule

### rtl/core/csa_queue.sv
module csa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csa_pkg::item_t  push_item,
	input  logic            pop,
	output csa_pkg::item_t  head,
	output csa_pkg::qstat_t qstat
);

	localparam int AW = $clog2(csa_pkg::QDEPTH);
	localparam int CW = $clog2(csa_pkg::QDEPTH + 1);

	csa_pkg::item_t mem_q [csa_pkg::QDEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign qstat.full  = (cnt_q == CW'(csa_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

### rtl/core/csa_back.sv
module csa_back #(
	parameter int W = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  csa_pkg::qstat_t qstat,
	output logic            pop,
	input  csa_pkg::item_t  head,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output csa_pkg::rsp_t   rsp
);

	localparam int H = (W + 1) / 2;
	localparam int P = 4 * H;
	localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		csa_pkg::op_t     op;
		csa_pkg::status_t st;
		logic             neg;
		logic [W-1:0]     res;
	} meta_t;

	typedef struct packed {
		logic [W-1:0] r;
		logic [W-1:0] q;
		logic [W-1:0] d;
	} dv_t;

	typedef struct packed {
		logic [2*H-1:0] ll;
		logic [2*H-1:0] lh;
		logic [2*H-1:0] hl;
		logic [2*H-1:0] hh;
	} pp_t;

	typedef struct packed {
		logic [2*H-1:0] ll;
		logic [2*H-1:0] hh;
		logic [2*H:0]   mid;
	} mid_t;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic dv_t div_step(input dv_t x);
		logic [W:0] t;
		logic [W:0] dif;
		dv_t        y;
		t   = {x.r, x.q[W-1]};
		dif = t - {1'b0, x.d};
		y.d = x.d;
		if (!dif[W]) begin
			y.r = dif[W-1:0];
			y.q = {x.q[W-2:0], 1'b1};
		end else begin
			y.r = t[W-1:0];
			y.q = {x.q[W-2:0], 1'b0};
		end
		return y;
	endfunction

	logic           en;
	logic           v_s0;
	csa_pkg::item_t ent_s0;
	logic           v_s    [1:W];
	meta_t          meta_s [1:W];
	dv_t            dv_s   [1:W];
	meta_t          meta_nx [1:W-1];
	pp_t            pp_s1;
	mid_t           mid_s2;
	logic [P-1:0]   prod_s3;
	logic           rsp_valid_q;
	csa_pkg::rsp_t  rsp_q;

	logic [W-1:0]   a_w, b_w, am_w, bm_w, sum_w;
	logic [H-1:0]   al, ah, bl, bh;
	logic           add_ovf;
	meta_t          meta1;
	dv_t            dv_init;
	logic [W-1:0]   lim, mres;
	logic           movf;
	logic [W-1:0]   quo, dres, pick;

	// Advance everything unless the finished word is held by the consumer.
	assign en        = !rsp_valid_q || !rsp_stall;
	assign pop       = en && !qstat.empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s0 <= head;
		end
	end

	always_comb begin
		a_w  = ent_s0.a[W-1:0];
		b_w  = ent_s0.b[W-1:0];
		am_w = ent_s0.am[W-1:0];
		bm_w = ent_s0.bm[W-1:0];
		if (ent_s0.op == csa_pkg::OP_SUB) begin
			sum_w   = a_w - b_w;
			add_ovf = (a_w[W-1] ^ b_w[W-1]) & (a_w[W-1] ^ sum_w[W-1]);
		end else begin
			sum_w   = a_w + b_w;
			add_ovf = (a_w[W-1] ^ sum_w[W-1]) & (b_w[W-1] ^ sum_w[W-1]);
		end
		meta1.op  = ent_s0.op;
		meta1.neg = ent_s0.neg;
		meta1.res = sum_w;
		meta1.st  = ent_s0.st;
		if ((ent_s0.op == csa_pkg::OP_ADD || ent_s0.op == csa_pkg::OP_SUB) && add_ovf) begin
			meta1.st = csa_pkg::ST_OVF;
		end
		dv_init.r = '0;
		dv_init.q = am_w;
		dv_init.d = bm_w;
		al = am_w[H-1:0];
		ah = H'(am_w[W-1:H]);
		bl = bm_w[H-1:0];
		bh = H'(bm_w[W-1:H]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[1] <= 1'b0;
		end else if (en) begin
			v_s[1] <= v_s0;
		end
	end

	// Multiplier: four half-width products, then the middle sum, then the total.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[1]   <= meta1;
			dv_s[1]     <= div_step(dv_init);
			pp_s1.ll    <= (2*H)'(al) * (2*H)'(bl);
			pp_s1.lh    <= (2*H)'(al) * (2*H)'(bh);
			pp_s1.hl    <= (2*H)'(ah) * (2*H)'(bl);
			pp_s1.hh    <= (2*H)'(ah) * (2*H)'(bh);
			mid_s2.ll   <= pp_s1.ll;
			mid_s2.hh   <= pp_s1.hh;
			mid_s2.mid  <= (2*H+1)'(pp_s1.lh) + (2*H+1)'(pp_s1.hl);
			prod_s3     <= {mid_s2.hh, mid_s2.ll} + (P'(mid_s2.mid) << H);
		end
	end

	// Product magnitude must stay within the signed range for its sign.
	always_comb begin
		lim  = meta_s[3].neg ? MIN_W : MAX_W;
		movf = (prod_s3[P-1:W] != '0) || (prod_s3[W-1:0] > lim);
		mres = meta_s[3].neg ? ('0 - prod_s3[W-1:0]) : prod_s3[W-1:0];
	end

	for (genvar k = 1; k < W; k++) begin : g_stage
		if (k == 3) begin : g_mul
			always_comb begin
				meta_nx[k] = meta_s[k];
				if (meta_s[k].op == csa_pkg::OP_MUL) begin
					meta_nx[k].st  = movf ? csa_pkg::ST_OVF : csa_pkg::ST_OK;
					meta_nx[k].res = mres;
				end
			end
		end else begin : g_pass
			assign meta_nx[k] = meta_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k+1] <= meta_nx[k];
				dv_s[k+1]   <= div_step(dv_s[k]);
			end
		end
	end

	always_comb begin
		quo  = dv_s[W].q;
		dres = meta_s[W].neg ? ('0 - quo) : quo;
		pick = (meta_s[W].op == csa_pkg::OP_DIV) ? dres : meta_s[W].res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.status <= meta_s[W].st;
			rsp_q.result <= (meta_s[W].st == csa_pkg::ST_OK) ? 64'($signed(pick)) : '0;
		end
	end

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.status == csa_pkg::ST_OK || rsp_q.status == csa_pkg::ST_OVF
			|| rsp_q.status == csa_pkg::ST_DIV0))
		else $error("undefined status code on output");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != csa_pkg::ST_OK) |-> (rsp_q.result == '0))
		else $error("error word carries a nonzero result");

	a_div0_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[W] && meta_s[W].op == csa_pkg::OP_DIV && dv_s[W].d == '0)
		|-> (meta_s[W].st == csa_pkg::ST_DIV0))
		else $error("zero divisor reached the end without a flag");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s[W]))
		else $error("pipeline moved while output was held");
`endif

endmodule

### rtl/core/checked_signed_alu_core.sv
// Throughput: one word per cycle for any mix of add, subtract, multiply,
//   divide, while rsp_stall does not hold the output word.
// Reset: arst_n clears all valid bits, queue pointers and the output valid;
//   data registers are not reset and no clearing pass runs.
module checked_signed_alu_core #(
	parameter int DATA_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  csa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output csa_pkg::rsp_t rsp
);

	// Front to queue.
	logic            push;
	csa_pkg::item_t  push_item;
	csa_pkg::qstat_t qstat;

	// Queue to back.
	logic            pop;
	csa_pkg::item_t  head;

	// Front: register the request word, keep the low working-width bits of the
	// operands, take magnitudes and flag divide errors early.
	csa_front #(
		.W (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// Short queue: absorb the words in flight while the back part is held,
	// so the front and back stall on their own.
	csa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back: add/subtract in the first stage, split multiply over three
	// stages, restoring divide one quotient bit per stage, then the
	// output register with sign fix and error zeroing.
	csa_back #(
		.W (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop       (pop),
		.head      (head),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
